>>> src/tkcs_pkg.sv
// Shared types, constants and defaults for the top-k cache set selector.
package tkcs_pkg;

    localparam int DefDemandDepth = 64;
    localparam int DefMaxCached = 16;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;

    localparam logic [4:0] LIMIT_RESET = 5'd8;

    typedef struct packed {
        logic        kind;
        logic [31:0] chunk_key;
        logic [15:0] weight;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] chunk_ident;
        logic [4:0]  cached_count;
        logic        overflow;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] weight;
    } entry_t;

endpackage

>>> src/tkcs_demand_mem.sv
// Single-port demand table memory holding chunk ids and accumulated weights.
module tkcs_demand_mem #(
    parameter int DEPTH = tkcs_pkg::DefDemandDepth,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  tkcs_pkg::entry_t  wdata,
    output tkcs_pkg::entry_t  rdata
);

    tkcs_pkg::entry_t mem [DEPTH];
    tkcs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/top_k_cache_set_selector.sv
// Top level of the top-k cache set selector.
//
// Demand requests and ticks arrive one at a time on the req channel; the block takes no
// new transfer until the current item is finished. A request walks the occupied part of
// the single-port demand table, reading and comparing one occupied entry per step, and
// adds its weight to the matching entry or appends a new one. A tick reads every occupied
// entry into a row of MAX_CACHED insertion cells, sorts the winners by id, then compares
// them with the cached set, one step per cycle, and sends at most one result per cycle
// on the res channel while it is not stalled. The demand table needs no clearing pass.
module top_k_cache_set_selector #(
    parameter int DEMAND_DEPTH = tkcs_pkg::DefDemandDepth,
    parameter int MAX_CACHED = tkcs_pkg::DefMaxCached
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_data,
    input  logic            req_valid,
    output logic            req_stall,
    input  tkcs_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_stall,
    output tkcs_pkg::res_t  res
);

    localparam int AW = $clog2(DEMAND_DEPTH);
    localparam int FW = $clog2(DEMAND_DEPTH + 1);
    localparam int CW = $clog2(MAX_CACHED + 1);
    localparam int IW = (MAX_CACHED > 1) ? $clog2(MAX_CACHED) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RQ_RD  = 4'd1;
    localparam logic [3:0] S_RQ_CMP = 4'd2;
    localparam logic [3:0] S_TK_RD  = 4'd3;
    localparam logic [3:0] S_TK_INS = 4'd4;
    localparam logic [3:0] S_SORT   = 4'd5;
    localparam logic [3:0] S_START  = 4'd6;
    localparam logic [3:0] S_STOP   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [4:0]        limit_reg;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [FW-1:0]     scan_reg, scan_next;
    logic              ovf_reg, ovf_next;
    logic [31:0]       cur_id_reg, cur_id_next;
    logic [15:0]       cur_w_reg, cur_w_next;
    logic [CW-1:0]     pass_reg, pass_next;
    logic [CW-1:0]     ci_reg, ci_next;
    logic [CW-1:0]     cj_reg, cj_next;
    logic [CW-1:0]     csize_reg, csize_next;
    logic [CW-1:0]     nsel;
    logic [CW-1:0]     lim;
    logic              res_valid_reg, res_valid_next;
    tkcs_pkg::res_t    res_reg, res_next;

    logic [31:0]       top_id_reg [MAX_CACHED];
    logic [31:0]       top_w_reg [MAX_CACHED];
    logic              top_v_reg [MAX_CACHED];
    logic [31:0]       top_id_next [MAX_CACHED];
    logic [31:0]       top_w_next [MAX_CACHED];
    logic              top_v_next [MAX_CACHED];
    logic [31:0]       cache_id_reg [MAX_CACHED];
    logic [31:0]       cache_id_next [MAX_CACHED];
    logic              above [MAX_CACHED];

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    tkcs_pkg::entry_t  mem_wdata, mem_rdata;
    logic              out_free;
    logic [32:0]       sum;
    logic [31:0]       a_id, b_id;
    logic              i_end, j_end;

    tkcs_demand_mem #(
        .DEPTH (DEMAND_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        if (int'(limit_reg) > MAX_CACHED)
        begin
            lim = CW'(MAX_CACHED);
        end
        else
        begin
            lim = CW'(limit_reg);
        end
    end

    always_comb
    begin
        nsel = '0;
        for (int c = 0; c < MAX_CACHED; c++)
        begin
            if (top_v_reg[c])
            begin
                nsel = CW'(c + 1);
            end
        end
    end

    assign sum = {1'b0, mem_rdata.weight} + {17'd0, cur_w_reg};
    assign a_id = top_id_reg[ci_reg[IW-1:0]];
    assign b_id = cache_id_reg[cj_reg[IW-1:0]];
    assign i_end = (ci_reg == nsel);
    assign j_end = (cj_reg == csize_reg);

    always_comb
    begin
        for (int c = 0; c < MAX_CACHED; c++)
        begin
            above[c] = top_v_reg[c] && ((top_w_reg[c] > mem_rdata.weight) ||
                       ((top_w_reg[c] == mem_rdata.weight) && (top_id_reg[c] > mem_rdata.id)));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        scan_next = scan_reg;
        ovf_next = ovf_reg;
        cur_id_next = cur_id_reg;
        cur_w_next = cur_w_reg;
        pass_next = pass_reg;
        ci_next = ci_reg;
        cj_next = cj_reg;
        csize_next = csize_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next = res_reg;
        top_id_next = top_id_reg;
        top_w_next = top_w_reg;
        top_v_next = top_v_reg;
        cache_id_next = cache_id_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = scan_reg[AW-1:0];
        mem_wdata = '{id: cur_id_reg, weight: {16'd0, cur_w_reg}};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_id_next = req.chunk_key;
                    cur_w_next = req.weight;
                    scan_next = '0;
                    if (req.kind == tkcs_pkg::KIND_TICK)
                    begin
                        for (int c = 0; c < MAX_CACHED; c++)
                        begin
                            top_v_next[c] = 1'b0;
                        end
                        state_next = S_TK_RD;
                    end
                    else
                    begin
                        state_next = S_RQ_RD;
                    end
                end
            end
            S_RQ_RD:
            begin
                if (scan_reg == fill_reg)
                begin
                    if (int'(fill_reg) == DEMAND_DEPTH)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                    state_next = S_RQ_CMP;
                end
            end
            S_RQ_CMP:
            begin
                if (mem_rdata.id == cur_id_reg)
                begin
                    mem_we = 1'b1;
                    mem_wdata.weight = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + FW'(1);
                    state_next = S_RQ_RD;
                end
            end
            S_TK_RD:
            begin
                if (scan_reg == fill_reg)
                begin
                    for (int c = 0; c < MAX_CACHED; c++)
                    begin
                        if (c >= int'(lim))
                        begin
                            top_v_next[c] = 1'b0;
                        end
                    end
                    pass_next = '0;
                    state_next = S_SORT;
                end
                else
                begin
                    mem_re = 1'b1;
                    state_next = S_TK_INS;
                end
            end
            S_TK_INS:
            begin
                for (int c = 0; c < MAX_CACHED; c++)
                begin
                    if (!above[c])
                    begin
                        if (c == 0 || above[(c > 0) ? c - 1 : 0])
                        begin
                            top_id_next[c] = mem_rdata.id;
                            top_w_next[c] = mem_rdata.weight;
                            top_v_next[c] = 1'b1;
                        end
                        else
                        begin
                            top_id_next[c] = top_id_reg[(c > 0) ? c - 1 : 0];
                            top_w_next[c] = top_w_reg[(c > 0) ? c - 1 : 0];
                            top_v_next[c] = top_v_reg[(c > 0) ? c - 1 : 0];
                        end
                    end
                end
                scan_next = scan_reg + FW'(1);
                state_next = S_TK_RD;
            end
            S_SORT:
            begin
                if (int'(pass_reg) >= MAX_CACHED)
                begin
                    ci_next = '0;
                    cj_next = '0;
                    state_next = S_START;
                end
                else
                begin
                    for (int c = 0; c + 1 < MAX_CACHED; c++)
                    begin
                        if ((c % 2) == int'(pass_reg[0]) &&
                            ({!top_v_reg[c], top_id_reg[c]} >
                             {!top_v_reg[c + 1], top_id_reg[c + 1]}))
                        begin
                            top_id_next[c] = top_id_reg[c + 1];
                            top_v_next[c] = top_v_reg[c + 1];
                            top_id_next[c + 1] = top_id_reg[c];
                            top_v_next[c + 1] = top_v_reg[c];
                        end
                    end
                    pass_next = pass_reg + CW'(1);
                end
            end
            S_START:
            begin
                if (i_end)
                begin
                    ci_next = '0;
                    cj_next = '0;
                    state_next = S_STOP;
                end
                else if (!j_end && b_id < a_id)
                begin
                    cj_next = cj_reg + CW'(1);
                end
                else if (!j_end && b_id == a_id)
                begin
                    ci_next = ci_reg + CW'(1);
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{action: tkcs_pkg::ACT_START, chunk_ident: a_id,
                                 cached_count: 5'd0, overflow: 1'b0, last: 1'b0};
                    ci_next = ci_reg + CW'(1);
                end
            end
            S_STOP:
            begin
                if (j_end)
                begin
                    state_next = S_DONE;
                end
                else if (!i_end && a_id < b_id)
                begin
                    ci_next = ci_reg + CW'(1);
                end
                else if (!i_end && a_id == b_id)
                begin
                    cj_next = cj_reg + CW'(1);
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{action: tkcs_pkg::ACT_STOP, chunk_ident: b_id,
                                 cached_count: 5'd0, overflow: 1'b0, last: 1'b0};
                    cj_next = cj_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{action: tkcs_pkg::ACT_DONE, chunk_ident: 32'd0,
                                 cached_count: 5'(nsel), overflow: ovf_reg, last: 1'b1};
                    cache_id_next = top_id_reg;
                    csize_next = nsel;
                    fill_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= tkcs_pkg::LIMIT_RESET;
            fill_reg <= '0;
            scan_reg <= '0;
            ovf_reg <= 1'b0;
            pass_reg <= '0;
            ci_reg <= '0;
            cj_reg <= '0;
            csize_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_CACHED; c++)
            begin
                top_v_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            scan_reg <= scan_next;
            ovf_reg <= ovf_next;
            pass_reg <= pass_next;
            ci_reg <= ci_next;
            cj_reg <= cj_next;
            csize_reg <= csize_next;
            res_valid_reg <= res_valid_next;
            top_v_reg <= top_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_id_reg <= cur_id_next;
        cur_w_reg <= cur_w_next;
        res_reg <= res_next;
        top_id_reg <= top_id_next;
        top_w_reg <= top_w_next;
        cache_id_reg <= cache_id_next;
    end

endmodule

>>> tb/top_k_cache_set_selector_tb.sv
// Self-checking testbench for the top-k cache set selector, with its own predictor.
`timescale 1ns / 100ps

module top_k_cache_set_selector_tb;

    localparam int Depth = tkcs_pkg::DefDemandDepth;
    localparam int MaxCached = tkcs_pkg::DefMaxCached;
    localparam int DrainCycles = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    tkcs_pkg::req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    tkcs_pkg::res_t res;

    tkcs_pkg::req_t pending_reqs[$];
    tkcs_pkg::res_t expected_res[$];

    logic [31:0] demand_id[Depth];
    logic [31:0] demand_wt[Depth];
    bit demand_used[Depth];
    logic [31:0] cached_set[$];
    bit table_overflowed;
    logic [4:0] limit_reg;

    int issued = 0;
    int accepted = 0;
    int src_gap = 0;
    bit src_hold = 1'b0;
    int sink_gap = 0;
    int sink_hold = 0;
    bit quiet = 1'b0;
    int errors = 0;
    int results_seen = 0;
    int ticks_seen = 0;

    top_k_cache_set_selector u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_demand(logic [31:0] id, logic [15:0] w);
        int free_slot;
        logic [32:0] sum;
        free_slot = -1;
        for (int i = 0; i < Depth; i++)
        begin
            if (demand_used[i])
            begin
                if (demand_id[i] == id)
                begin
                    sum = {1'b0, demand_wt[i]} + {17'd0, w};
                    demand_wt[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    return;
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (free_slot < 0)
        begin
            table_overflowed = 1'b1;
            return;
        end
        demand_used[free_slot] = 1'b1;
        demand_id[free_slot] = id;
        demand_wt[free_slot] = {16'd0, w};
    endfunction

    function automatic void select_top_k();
        int lim;
        int rank;
        logic [31:0] chosen[$];
        tkcs_pkg::res_t r;
        lim = (int'(limit_reg) > MaxCached) ? MaxCached : int'(limit_reg);
        for (int i = 0; i < Depth; i++)
        begin
            if (!demand_used[i])
                continue;
            rank = 0;
            for (int j = 0; j < Depth; j++)
                if (j != i && demand_used[j] &&
                    (demand_wt[j] > demand_wt[i] ||
                     (demand_wt[j] == demand_wt[i] && demand_id[j] > demand_id[i])))
                    rank++;
            if (rank < lim)
                chosen.push_back(demand_id[i]);
        end
        chosen.sort();
        foreach (chosen[i])
        begin
            bit found;
            found = 1'b0;
            foreach (cached_set[k])
                if (cached_set[k] == chosen[i])
                    found = 1'b1;
            if (!found)
            begin
                r = '{action: tkcs_pkg::ACT_START, chunk_ident: chosen[i], default: '0};
                expected_res.push_back(r);
            end
        end
        foreach (cached_set[i])
        begin
            bit found;
            found = 1'b0;
            foreach (chosen[k])
                if (chosen[k] == cached_set[i])
                    found = 1'b1;
            if (!found)
            begin
                r = '{action: tkcs_pkg::ACT_STOP, chunk_ident: cached_set[i], default: '0};
                expected_res.push_back(r);
            end
        end
        r.action = tkcs_pkg::ACT_DONE;
        r.chunk_ident = '0;
        r.cached_count = 5'(chosen.size());
        r.overflow = table_overflowed;
        r.last = 1'b1;
        expected_res.push_back(r);
        cached_set = chosen;
        for (int i = 0; i < Depth; i++)
            demand_used[i] = 1'b0;
        table_overflowed = 1'b0;
    endfunction

    // Transfers on the request channel update the predictor.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            accepted++;
            if (req.kind == tkcs_pkg::KIND_TICK)
                select_top_k();
            else
                add_demand(req.chunk_key, req.weight);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && accepted != issued))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !src_hold)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                issued++;
                if (!quiet && $urandom_range(7) == 0)
                    src_gap = $urandom_range(1, 11);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold--;
            res_stall <= 1'b1;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (!quiet && $urandom_range(5) == 0)
                sink_gap = $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        tkcs_pkg::res_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_res.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, res);
                errors++;
            end
            else
            begin
                exp_r = expected_res.pop_front();
                if (res.last)
                    ticks_seen++;
                if (res.action !== exp_r.action || res.chunk_ident !== exp_r.chunk_ident ||
                    res.cached_count !== exp_r.cached_count ||
                    res.overflow !== exp_r.overflow || res.last !== exp_r.last)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, res);
                    errors++;
                end
            end
        end
    end

    task automatic push_demand(logic [31:0] id, logic [15:0] w);
        pending_reqs.push_back('{kind: tkcs_pkg::KIND_REQUEST, chunk_key: id, weight: w});
    endtask

    task automatic push_tick();
        pending_reqs.push_back('{kind: tkcs_pkg::KIND_TICK, chunk_key: $urandom,
                                 weight: 16'($urandom)});
    endtask

    task automatic wait_settled();
        while (pending_reqs.size() > 0 || accepted != issued || expected_res.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    initial
    begin
        int n;
        int pool_base;
        for (int i = 0; i < Depth; i++)
            demand_used[i] = 1'b0;
        table_overflowed = 1'b0;
        limit_reg = tkcs_pkg::LIMIT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit: extremes of id and weight, equal weights on two ids, an empty tick.
        push_tick();
        push_demand(32'h0000_0000, 16'h0000);
        push_demand(32'hFFFF_FFFF, 16'hFFFF);
        push_demand(32'h0000_0005, 16'd7);
        push_demand(32'h0000_0009, 16'd7);
        push_demand(32'h0000_0005, 16'd0);
        push_tick();
        push_tick();
        wait_settled();

        // Full set, then a receiver stall long enough to back up the request side.
        write_limit(5'd16);
        for (int i = 0; i < 16; i++)
            push_demand(32'h8000_0000 + i, 16'(i + 1));
        push_tick();
        wait_settled();
        sink_hold = 300;
        for (int i = 0; i < 16; i++)
            push_demand(32'h0100_0000 + i, 16'(100 + i));
        push_tick();
        for (int i = 0; i < 8; i++)
            push_demand($urandom, 16'($urandom));
        push_tick();
        wait_settled();

        // Limit beyond capacity and a table overflow.
        write_limit(5'd31);
        for (int i = 0; i < Depth + 3; i++)
            push_demand(32'h0200_0000 + i, 16'($urandom));
        push_tick();
        wait_settled();

        // Limit zero drops every cached chunk.
        write_limit(5'd0);
        push_demand(32'h1234_5678, 16'hFFFF);
        push_tick();
        wait_settled();

        // Limit one with repeated heavy weights on one chunk.
        write_limit(5'd1);
        for (int i = 0; i < 4; i++)
            push_demand(32'hA5A5_5A5A, 16'hFFFF);
        push_demand(32'h0000_0001, 16'h0001);
        push_tick();
        wait_settled();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 5)
                0: write_limit(5'd0);
                1: write_limit(5'd16);
                2: write_limit(5'd31);
                default: write_limit(5'($urandom_range(1, 15)));
            endcase
            if (phase == 8)
                quiet = 1'b1;
            if (phase == 5)
            begin
                src_hold = 1'b1;
                while (expected_res.size() > 0)
                    @(posedge clk);
                src_hold = 1'b0;
            end
            for (int t = 0; t < 2; t++)
            begin
                n = $urandom_range(4, 18);
                pool_base = $urandom;
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(3) == 0)
                        push_demand($urandom, 16'($urandom));
                    else
                        push_demand(32'(pool_base + $urandom_range(0, 20)),
                                    ($urandom_range(1) == 0) ? 16'($urandom_range(0, 3))
                                                             : 16'($urandom));
                end
                push_tick();
            end
            wait_settled();
        end

        $display("Covered %0d ticks and %0d results across limits 0, 1, 16, 31 and random.",
                 ticks_seen, results_seen);
        $display("Included ties, table overflow and input backpressure.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
